FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside of reset
`define TFCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// check a property on every clock edge, reset included
`define TFCB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/tfcb_pkg.sv
// types, constants and the crc byte update for the telemetry frame builder
package tfcb_pkg;

    localparam int unsigned FRAME_BYTES = 31;
    localparam int unsigned BODY_BYTES  = 26;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
    localparam int unsigned BODY_W      = BODY_BYTES * 8;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] BODY_END = IDX_W'(BODY_BYTES);

    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    localparam logic [7:0] START_RESET = 8'hAA;
    localparam logic [7:0] END_RESET   = 8'h55;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = CFG_IDX_W'(1);

    // one telemetry set plus the counter value taken at accept
    typedef struct packed {
        logic [7:0]         counter;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [31:0]        pressure_bits;
        logic [31:0]        temperature_bits;
        logic [31:0]        altitude_bits;
    } t_item;

    // reflected crc-32 update for one byte, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/tfcb_in_buf.sv
// one-entry input register that holds the next telemetry item
`include "assert_macros.svh"

module tfcb_in_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tfcb_pkg::t_item i_item,
    output logic           o_item_valid,
    output tfcb_pkg::t_item o_item,
    input  logic           i_take
);

    logic           r_valid;
    logic           n_valid;
    tfcb_pkg::t_item r_item;
    logic           accept;

    // full and not being drained this cycle
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    `TFCB_ASSERT(a_hold_item, (r_valid && !i_take) |=> r_valid, "held item was dropped")
    `TFCB_ASSERT(a_take_valid, i_take |-> r_valid, "item taken from empty buffer")

endmodule

FILE: rtl/core/tfcb_serializer.sv
// frame serializer: one byte per cycle while the output is not stalled, with a running crc-32
`include "assert_macros.svh"

module tfcb_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  tfcb_pkg::t_item i_item,
    output logic            o_take,
    input  logic [7:0]      i_start_byte,
    input  logic [7:0]      i_end_byte,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic                         r_busy;
    logic                         n_busy;
    logic [tfcb_pkg::IDX_W-1:0]   r_idx;
    logic [tfcb_pkg::IDX_W-1:0]   n_idx;
    logic [tfcb_pkg::BODY_W-1:0]  r_body;
    logic [tfcb_pkg::BODY_W-1:0]  n_body;
    logic [31:0]                  r_crc;
    logic [31:0]                  n_crc;
    logic                         r_ov;
    logic                         n_ov;
    logic [7:0]                   r_ob;
    logic [7:0]                   n_ob;
    logic                         r_olast;
    logic                         n_olast;
    logic                         out_free;
    logic                         emit;
    logic                         load;
    logic [7:0]                   cur_byte;

    assign out_free = !r_ov || !i_stall;
    assign emit     = r_busy && out_free;
    assign load     = i_item_valid && (!r_busy || (emit && (r_idx == tfcb_pkg::LAST_IDX)));
    assign o_take   = load;

    // pick the byte for the current frame position
    always_comb begin
        if (r_idx < tfcb_pkg::BODY_END) begin
            cur_byte = r_body[7:0];
        end else if (r_idx == tfcb_pkg::LAST_IDX) begin
            cur_byte = i_end_byte;
        end else begin
            cur_byte = r_crc[7:0] ^ tfcb_pkg::BYTE_MASK;
        end
    end

    // next state of the frame walk and the output register
    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_body  = r_body;
        n_crc   = r_crc;
        n_ov    = r_ov;
        n_ob    = r_ob;
        n_olast = r_olast;
        if (out_free) begin
            n_ov = emit;
        end
        if (emit) begin
            n_ob    = cur_byte;
            n_olast = (r_idx == tfcb_pkg::LAST_IDX);
            n_idx   = r_idx + {{(tfcb_pkg::IDX_W-1){1'b0}}, 1'b1};
            if (r_idx < tfcb_pkg::BODY_END) begin
                n_body = r_body >> 8;
                n_crc  = tfcb_pkg::crc_byte(r_crc, r_body[7:0]);
            end else begin
                n_crc  = r_crc >> 8;
            end
            if (r_idx == tfcb_pkg::LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_crc  = tfcb_pkg::CRC_INIT;
            n_body = {i_item.altitude_bits, i_item.temperature_bits, i_item.pressure_bits,
                      i_item.gyro_z, i_item.gyro_y, i_item.gyro_x,
                      i_item.accel_z, i_item.accel_y, i_item.accel_x,
                      i_item.counter, i_start_byte};
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ov   <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_body  <= n_body;
        r_crc   <= n_crc;
        r_ob    <= n_ob;
        r_olast <= n_olast;
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_olast;

    `TFCB_ASSERT(a_idx_range, r_busy |-> (r_idx <= tfcb_pkg::LAST_IDX), "frame index past end")
    `TFCB_ASSERT(a_last_out, (emit && (r_idx == tfcb_pkg::LAST_IDX)) |=> (r_ov && r_olast),
        "end byte not flagged")
    `TFCB_ASSERT(a_load_init, load |=> (r_busy && (r_idx == '0) && (r_crc == tfcb_pkg::CRC_INIT)),
        "frame did not start clean")
    `TFCB_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (!r_busy && !r_ov), "reset left frame active")

endmodule

FILE: rtl/core/telemetry_frame_crc32_builder_unit.sv
// top level of the telemetry frame builder with crc-32
//
// Each accepted telemetry item becomes a 31-byte frame: start byte, message
// counter, six 16-bit samples and three 32-bit float patterns (low byte
// first), a reflected crc-32 over those 26 bytes (low byte first) and the end
// byte, which carries o_frame_last. Bytes leave at one per cycle while the
// receiver does not stall. One more item is held in an input register while
// a frame goes out, and the next frame follows the last byte with no gap.
// An item accepted into an idle block passes the input register and the
// serializer's frame state before its first byte reaches the output
// register. Configuration writes are taken in any cycle and are meant for idle
// periods; there is no clearing pass after reset.
`include "assert_macros.svh"

module telemetry_frame_crc32_builder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [15:0]             i_accel_x,
    input  logic signed [15:0]             i_accel_y,
    input  logic signed [15:0]             i_accel_z,
    input  logic signed [15:0]             i_gyro_x,
    input  logic signed [15:0]             i_gyro_y,
    input  logic signed [15:0]             i_gyro_z,
    input  logic [31:0]                    i_pressure_bits,
    input  logic [31:0]                    i_temperature_bits,
    input  logic [31:0]                    i_altitude_bits,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic                           o_frame_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tfcb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    logic            r_start_byte;
    logic [7:0]      r_start;
    logic [7:0]      r_end;
    logic [7:0]      r_counter;
    logic            in_accept;
    logic            take;
    logic            item_valid;
    tfcb_pkg::t_item in_item;
    tfcb_pkg::t_item buf_item;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    // configuration registers and message counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= tfcb_pkg::START_RESET;
            r_end     <= tfcb_pkg::END_RESET;
            r_counter <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == tfcb_pkg::REG_START_BYTE)) begin
                r_start <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == tfcb_pkg::REG_END_BYTE)) begin
                r_end <= i_cfg_data;
            end
            if (in_accept) begin
                r_counter <= r_counter + 8'd1;
            end
        end
    end

    // tracks a config write to the start byte, used only by the checks below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 1'b0;
        end else begin
            r_start_byte <= i_cfg_valid && (i_cfg_index == tfcb_pkg::REG_START_BYTE);
        end
    end

    // gather the item with the counter value it is sent with
    always_comb begin
        in_item.counter          = r_counter;
        in_item.accel_x          = i_accel_x;
        in_item.accel_y          = i_accel_y;
        in_item.accel_z          = i_accel_z;
        in_item.gyro_x           = i_gyro_x;
        in_item.gyro_y           = i_gyro_y;
        in_item.gyro_z           = i_gyro_z;
        in_item.pressure_bits    = i_pressure_bits;
        in_item.temperature_bits = i_temperature_bits;
        in_item.altitude_bits    = i_altitude_bits;
    end

    tfcb_in_buf u_in_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_item       (in_item),
        .o_item_valid (item_valid),
        .o_item       (buf_item),
        .i_take       (take)
    );

    tfcb_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (buf_item),
        .o_take       (take),
        .i_start_byte (r_start),
        .i_end_byte   (r_end),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_byte       (o_out_byte),
        .o_last       (o_frame_last)
    );

    `TFCB_ASSERT(a_cnt_step, in_accept |=> (r_counter == $past(r_counter) + 8'd1),
        "message counter did not advance")
    `TFCB_ASSERT(a_start_wr, r_start_byte |-> (r_start == $past(i_cfg_data)),
        "start byte write lost")

endmodule

FILE: sim/tb.sv
// testbench for the telemetry frame builder: directed table, then random frames
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_PAUSE     = 4;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 30;
    localparam int TABLE_ROWS     = 15;

    // one telemetry set, raw bit patterns
    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [15:0] gx;
        logic [15:0] gy;
        logic [15:0] gz;
        logic [31:0] press;
        logic [31:0] temp;
        logic [31:0] alt;
    } t_telem;

    // stimulus row: a register write or an item, with optional typed frame header/trailer
    typedef struct packed {
        bit                             is_reg;
        logic [tfcb_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [7:0]                     reg_data;
        t_telem                         smp;
        bit                             typed;
        logic [7:0]                     x_start;
        logic [7:0]                     x_count;
        logic [7:0]                     x_end;
    } t_row;

    // one expected frame byte
    typedef struct packed {
        logic [4:0] pos;
        logic [7:0] val;
        logic       last;
    } t_frame_byte;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic signed [15:0]             i_accel_x;
    logic signed [15:0]             i_accel_y;
    logic signed [15:0]             i_accel_z;
    logic signed [15:0]             i_gyro_x;
    logic signed [15:0]             i_gyro_y;
    logic signed [15:0]             i_gyro_z;
    logic [31:0]                    i_pressure_bits;
    logic [31:0]                    i_temperature_bits;
    logic [31:0]                    i_altitude_bits;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [7:0]                     o_out_byte;
    logic                           o_frame_last;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tfcb_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]                     i_cfg_data;

    // predictor state and expected frame bytes
    t_frame_byte frame_q[$];
    logic [7:0]  start_val;
    logic [7:0]  end_val;
    logic [7:0]  frame_count;
    t_row        drv_row;
    int          miss_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    telemetry_frame_crc32_builder_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_accel_x          (i_accel_x),
        .i_accel_y          (i_accel_y),
        .i_accel_z          (i_accel_z),
        .i_gyro_x           (i_gyro_x),
        .i_gyro_y           (i_gyro_y),
        .i_gyro_z           (i_gyro_z),
        .i_pressure_bits    (i_pressure_bits),
        .i_temperature_bits (i_temperature_bits),
        .i_altitude_bits    (i_altitude_bits),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_frame_last       (o_frame_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_telem tele(input logic [15:0] ax, ay, az, gx, gy, gz,
                                    input logic [31:0] pr, te, al);
        t_telem t;
        t = '{ax, ay, az, gx, gy, gz, pr, te, al};
        return t;
    endfunction

    function automatic t_row item_row(input t_telem t, input bit typed,
                                      input logic [7:0] xs, xc, xe);
        t_row r;
        r = '0;
        r.smp     = t;
        r.typed   = typed;
        r.x_start = xs;
        r.x_count = xc;
        r.x_end   = xe;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [tfcb_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [7:0] d);
        t_row r;
        r = '0;
        r.is_reg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = d;
        return r;
    endfunction

    // reflected crc-32, one data bit at a time, lsb first
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ tfcb_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // append one expected byte at the tail of the frame queue
    function automatic void queue_byte(input int pos, input logic [7:0] val, input logic last);
        t_frame_byte fb;
        fb.pos  = 5'(pos);
        fb.val  = val;
        fb.last = last;
        frame_q.insert(frame_q.size(), fb);
    endfunction

    // serialize one accepted set into expected frame bytes and advance the counter
    function automatic void queue_frame(input t_row r);
        logic [7:0]  body [tfcb_pkg::BODY_BYTES];
        logic [15:0] w16 [6];
        logic [31:0] w32 [3];
        logic [31:0] crc;
        body[0] = r.typed ? r.x_start : start_val;
        body[1] = r.typed ? r.x_count : frame_count;
        w16 = '{r.smp.ax, r.smp.ay, r.smp.az, r.smp.gx, r.smp.gy, r.smp.gz};
        w32 = '{r.smp.press, r.smp.temp, r.smp.alt};
        for (int k = 0; k < 6; k++) begin
            body[2 + 2*k] = w16[k][7:0];
            body[3 + 2*k] = w16[k][15:8];
        end
        for (int k = 0; k < 3; k++) begin
            for (int b = 0; b < 4; b++) begin
                body[14 + 4*k + b] = w32[k][8*b +: 8];
            end
        end
        crc = tfcb_pkg::CRC_INIT;
        for (int k = 0; k < tfcb_pkg::BODY_BYTES; k++) begin
            crc = crc32_update(crc, body[k]);
        end
        crc = crc ^ tfcb_pkg::CRC_INIT;
        for (int k = 0; k < tfcb_pkg::BODY_BYTES; k++) begin
            queue_byte(k, body[k], 1'b0);
        end
        for (int b = 0; b < 4; b++) begin
            queue_byte(tfcb_pkg::BODY_BYTES + b, crc[8*b +: 8], 1'b0);
        end
        queue_byte(tfcb_pkg::FRAME_BYTES - 1, r.typed ? r.x_end : end_val, 1'b1);
        frame_count = frame_count + 8'd1;
    endfunction

    task automatic report_miss(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        miss_count++;
    endtask

    // predictor, checker and watchdog, all sampled at the clock edge
    always @(posedge i_clk) begin
        t_frame_byte want;
        bit          hit;
        hit = 1'b0;
        if (!i_rst_n) begin
            start_val   = tfcb_pkg::START_RESET;
            end_val     = tfcb_pkg::END_RESET;
            frame_count = 8'd0;
            frame_q.delete();
        end else begin
            // register write
            if (i_cfg_valid && o_cfg_ready) begin
                hit = 1'b1;
                case (i_cfg_index)
                    tfcb_pkg::REG_START_BYTE: start_val = i_cfg_data;
                    tfcb_pkg::REG_END_BYTE:   end_val   = i_cfg_data;
                    default: ;
                endcase
            end
            // accepted item
            if (i_in_valid && !o_in_stall) begin
                hit = 1'b1;
                queue_frame(drv_row);
            end
            // accepted frame byte
            if (o_out_valid && !i_out_stall) begin
                hit = 1'b1;
                if (frame_q.size() == 0) begin
                    report_miss($sformatf("byte %02h with no frame pending", o_out_byte));
                end else begin
                    want = frame_q.pop_front();
                    if (o_out_byte !== want.val) begin
                        report_miss($sformatf("byte %0d: got %02h want %02h",
                                              want.pos, o_out_byte, want.val));
                    end
                    if (o_frame_last !== want.last) begin
                        report_miss($sformatf("byte %0d: frame_last got %b want %b",
                                              want.pos, o_frame_last, want.last));
                    end
                end
            end
        end
        // nothing moving for too long
        if (hit || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_set(input t_row r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        drv_row            <= r;
        i_accel_x          <= r.smp.ax;
        i_accel_y          <= r.smp.ay;
        i_accel_z          <= r.smp.az;
        i_gyro_x           <= r.smp.gx;
        i_gyro_y           <= r.smp.gy;
        i_gyro_z           <= r.smp.gz;
        i_pressure_bits    <= r.smp.press;
        i_temperature_bits <= r.smp.temp;
        i_altitude_bits    <= r.smp.alt;
        i_in_valid         <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait until every expected byte is out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tfcb_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] d);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // float patterns, with infinities, nan and denormals now and then
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7F80_0000;
            3:       return 32'h7FC0_0001;
            4:       return 32'h0000_0001 + ($urandom & 32'h007F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        t_row table_rows[TABLE_ROWS];
        int   idle_tab[4];
        int   stall_tab[4];
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_accel_x          = '0;
        i_accel_y          = '0;
        i_accel_z          = '0;
        i_gyro_x           = '0;
        i_gyro_y           = '0;
        i_gyro_z           = '0;
        i_pressure_bits    = '0;
        i_temperature_bits = '0;
        i_altitude_bits    = '0;
        i_out_stall        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        drv_row            = '0;
        idle_tab  = '{0, 66, 0, 23};
        stall_tab = '{0, 0, 66, 23};

        // directed table: reset values, field extremes, float specials, register extremes
        table_rows[0] = item_row(tele(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000), 1, 8'hAA, 8'd0, 8'h55);
        table_rows[1] = item_row(tele(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 8'hAA, 8'd1, 8'h55);
        table_rows[2] = item_row(tele(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000), 1, 8'hAA, 8'd2, 8'h55);
        table_rows[3] = item_row(tele(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 32'h7FC0_0000, 32'h7F80_0000, 32'h0000_0001), 1, 8'hAA, 8'd3, 8'h55);
        table_rows[4] = item_row(tele(16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE, 16'h00FF,
            16'hFF00, 32'hFF80_0000, 32'h8000_0000, 32'h007F_FFFF), 0, 8'h00, 8'h00, 8'h00);
        table_rows[5] = item_row(tele(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
            16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F), 0, 8'h00, 8'h00, 8'h00);
        table_rows[6] = item_row(tele(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
            16'h0006, 32'h3F80_0000, 32'hC000_0000, 32'h7F7F_FFFF), 0, 8'h00, 8'h00, 8'h00);
        table_rows[7] = reg_row(tfcb_pkg::REG_START_BYTE, 8'h00);
        table_rows[8] = reg_row(tfcb_pkg::REG_END_BYTE, 8'hFF);
        table_rows[9] = item_row(tele(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000), 1, 8'h00, 8'd7, 8'hFF);
        table_rows[10] = item_row(tele(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 8'h00, 8'd8, 8'hFF);
        table_rows[11] = reg_row(tfcb_pkg::REG_START_BYTE, 8'hFF);
        table_rows[12] = reg_row(tfcb_pkg::REG_END_BYTE, 8'h00);
        table_rows[13] = item_row(tele(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F,
            16'hF0F0, 32'h4120_0000, 32'hBF80_0000, 32'h0080_0000), 1, 8'hFF, 8'd9, 8'h00);
        table_rows[14] = item_row(tele(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000,
            16'h7FFF, 32'h7F80_0001, 32'hFFC0_0000, 32'h807F_FFFF), 1, 8'hFF, 8'd10, 8'h00);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        foreach (table_rows[k]) begin
            if (table_rows[k].is_reg) begin
                write_reg(table_rows[k].reg_idx, table_rows[k].reg_data);
            end else begin
                send_set(table_rows[k]);
            end
        end

        // random part: fresh register values, then one idling mix per phase
        for (int ph = 0; ph < 4; ph++) begin
            if ($urandom_range(0, 1)) begin
                write_reg(tfcb_pkg::REG_START_BYTE, pick_byte());
                write_reg(tfcb_pkg::REG_END_BYTE, pick_byte());
            end else begin
                write_reg(tfcb_pkg::REG_END_BYTE, pick_byte());
                write_reg(tfcb_pkg::REG_START_BYTE, pick_byte());
            end
            send_idle_pct = idle_tab[ph];
            stall_pct     = stall_tab[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_set(item_row(tele(pick16(), pick16(), pick16(), pick16(), pick16(),
                    pick16(), pick32(), pick32(), pick32()), 0, 8'h00, 8'h00, 8'h00));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (miss_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
